[hw/rtl/rgb_palette_indexer_macros.svh]
// assertion macros used by the palette indexer top module
`ifndef RGB_PALETTE_INDEXER_MACROS_SVH
`define RGB_PALETTE_INDEXER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define RPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpi assertion failed");
// next-cycle implication, checked out of reset
`define RPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpi assertion failed");
`else
`define RPI_ASSERT_IMP(lbl, ante, cons)
`define RPI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/rpi_pkg.sv]
`default_nettype none
package rpi_pkg;

  localparam int CFG_W = 9;

  typedef logic [23:0]      color_t;
  typedef logic [7:0]       idx_t;
  typedef logic [CFG_W-1:0] cfg_t;

  localparam cfg_t PE_RESET = cfg_t'(256);

  typedef enum logic [1:0] {
    ST_MATCHED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // search token walking down the row of cells
  typedef struct packed {
    logic    act;
    logic    done;
    idx_t    idx;
    status_t status;
  } tok_t;

  // signals fanned out from the top to every cell
  typedef struct packed {
    logic   en;
    logic   add_ok;
    color_t color;
  } bcast_t;

endpackage
`default_nettype wire

[hw/rtl/rgb_palette_indexer.sv]
// rgb_palette_indexer: assigns palette indices to a stream of 24-bit pixels.
// input channel: in_valid / in_stall with in_red, in_green, in_blue.
// result channel: out_valid / out_stall with out_palette_index and out_status
// (matched, added or full). one result per pixel, in order.
// cfg_we writes cfg_palette_entries (palette size, reset 256); write only
// while no pixel is in flight. values above MAX_COLORS act as MAX_COLORS.
// the color table is a row of MAX_COLORS cells, one stored color each. a
// search token enters cell 0 and moves one cell per cycle while the row is
// not frozen; the first cell holding the color, or the first free cell,
// resolves it and it rides on to the end of the row.
// a pixel's token passes from the head register through every cell in turn,
// and its result is then captured in the output register.
// in_stall is high while a pixel is in the row; a new pixel is taken while
// the previous result still waits in the output register.
// if out_stall holds a result and the next token reaches the row end, the
// whole row freezes until the result is taken.
// reset clears the color count and the palette size to 256; the stored
// colors are not cleared and no clearing pass is needed.
`default_nettype none
`include "rgb_palette_indexer_macros.svh"
module rgb_palette_indexer #(
  parameter int MAX_COLORS = 256
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_red,
  input  wire  [7:0] in_green,
  input  wire  [7:0] in_blue,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_palette_index,
  output logic [1:0] out_status,
  input  wire        cfg_we,
  input  wire  [8:0] cfg_palette_entries
);

  localparam int CNT_W = $clog2(MAX_COLORS + 1);
  localparam int CW    = rpi_pkg::CFG_W;
  localparam int SW    = CW + 1;
  localparam logic [CW-1:0] MAX_SIZE = CW'(MAX_COLORS);

  rpi_pkg::tok_t   chain_tok [MAX_COLORS+1];
  rpi_pkg::tok_t   head_tok_r;
  rpi_pkg::tok_t   head_tok_nxt;
  rpi_pkg::tok_t   tail_tok;
  rpi_pkg::bcast_t bc;
  rpi_pkg::color_t color_r;
  rpi_pkg::cfg_t   pe_r;
  rpi_pkg::cfg_t   eff_size;
  rpi_pkg::idx_t   out_idx_r;
  rpi_pkg::status_t out_status_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic            busy_r;
  logic            busy_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            in_xfer;
  logic            tail_take;
  logic            cnt_inc;

  assign in_stall  = busy_r;
  assign in_xfer   = in_valid && !busy_r;
  assign tail_tok  = chain_tok[MAX_COLORS];
  // freeze the row while a finished token cannot leave
  assign bc.en     = !(tail_tok.act && out_valid_r && out_stall);
  assign tail_take = tail_tok.act && bc.en;
  assign cnt_inc   = tail_take && (tail_tok.status == rpi_pkg::ST_ADDED);
  assign bc.color  = color_r;

  assign eff_size  = (pe_r > MAX_SIZE) ? MAX_SIZE : pe_r;
  assign bc.add_ok = (SW'(cnt_r) + SW'(1)) < SW'(eff_size);

  assign chain_tok[0] = head_tok_r;

  for (genvar g = 0; g < MAX_COLORS; g++) begin : g_cell
    rpi_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bc      (bc),
      .cnt     (cnt_r),
      .tok_in  (chain_tok[g]),
      .tok_out (chain_tok[g+1])
    );
  end

  always_comb begin
    head_tok_nxt = head_tok_r;
    priority if (in_xfer) begin
      head_tok_nxt.act    = 1'b1;
      head_tok_nxt.done   = 1'b0;
      head_tok_nxt.idx    = '0;
      head_tok_nxt.status = rpi_pkg::ST_FULL;
    end else if (bc.en) begin
      head_tok_nxt = '0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    priority if (in_xfer) begin
      busy_nxt = 1'b1;
    end else if (tail_take) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (tail_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cnt_inc) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_tok_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pe_r        <= rpi_pkg::PE_RESET;
    end else begin
      head_tok_r  <= head_tok_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        pe_r <= cfg_palette_entries;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      color_r <= {in_red, in_green, in_blue};
    end
    if (tail_take) begin
      out_idx_r    <= tail_tok.idx;
      out_status_r <= tail_tok.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_idx_r;
  assign out_status        = out_status_r;

  // a token is always resolved before it leaves the row
  `RPI_ASSERT_IMP(a_tail_resolved, tail_tok.act, tail_tok.done)
  // no token can reach the row end unless a pixel is in flight
  `RPI_ASSERT_IMP(a_idle_empty, !busy_r, !tail_tok.act && !head_tok_r.act)
  // the count never reaches the table depth
  `RPI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r < CNT_W'(MAX_COLORS))
  // an added color bumps the count by exactly one
  `RPI_ASSERT_NXT(a_cnt_step, cnt_inc, cnt_r == CNT_W'($past(cnt_r) + 1'b1))

endmodule
`default_nettype wire

[hw/rtl/rpi_cell.sv]
`default_nettype none
module rpi_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  wire              clk,
  input  wire              rst_n,
  input  rpi_pkg::bcast_t  bc,
  input  wire  [CNT_W-1:0] cnt,
  input  rpi_pkg::tok_t    tok_in,
  output rpi_pkg::tok_t    tok_out
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);

  rpi_pkg::color_t color_r;
  rpi_pkg::tok_t   tok_r;
  rpi_pkg::tok_t   tok_nxt;
  logic            live;
  logic            here;
  logic            hit;
  logic            wr_en;

  assign live  = tok_in.act && !tok_in.done;
  // this cell is the first free slot
  assign here  = (cnt == MY_POS);
  // only entries below the count hold stored colors
  assign hit   = (MY_POS < cnt) && (color_r == bc.color);
  assign wr_en = bc.en && live && here && bc.add_ok;

  always_comb begin
    tok_nxt = tok_in;
    if (live) begin
      priority if (hit) begin
        tok_nxt.done   = 1'b1;
        tok_nxt.idx    = rpi_pkg::idx_t'(CELL_IDX);
        tok_nxt.status = rpi_pkg::ST_MATCHED;
      end else if (here) begin
        tok_nxt.done = 1'b1;
        if (bc.add_ok) begin
          tok_nxt.idx    = rpi_pkg::idx_t'(CELL_IDX);
          tok_nxt.status = rpi_pkg::ST_ADDED;
        end else begin
          tok_nxt.idx    = '0;
          tok_nxt.status = rpi_pkg::ST_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (bc.en) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      color_r <= bc.color;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

[tb/rgb_palette_indexer_tb.sv]
`timescale 1ns / 100ps
module rgb_palette_indexer_tb;

  localparam int MAX_COLORS = 256;
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = MAX_COLORS + 20;
  localparam int CYCLE_LIMIT = 12000000;

  typedef struct packed {
    rpi_pkg::idx_t    idx;
    rpi_pkg::status_t status;
  } result_t;

  typedef enum bit {ROW_PIXEL, ROW_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    rpi_pkg::cfg_t   size;
    rpi_pkg::color_t color;
    bit              typed;
    result_t         expected;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_palette_index;
  logic [1:0] out_status;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_palette_entries = rpi_pkg::PE_RESET;

  // expected palette state
  rpi_pkg::color_t stored_colors [MAX_COLORS];
  int unsigned     stored_count = 0;
  rpi_pkg::cfg_t   size_reg = rpi_pkg::PE_RESET;

  result_t     pending_results [$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_req = 1'b0;
  logic        hold_active = 1'b0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_PIXEL, 9'd0,   24'h000000, 1'b1, '{8'd0, rpi_pkg::ST_ADDED}},
    '{ROW_PIXEL, 9'd0,   24'hFFFFFF, 1'b1, '{8'd1, rpi_pkg::ST_ADDED}},
    '{ROW_PIXEL, 9'd0,   24'h000000, 1'b1, '{8'd0, rpi_pkg::ST_MATCHED}},
    '{ROW_PIXEL, 9'd0,   24'hFFFFFF, 1'b1, '{8'd1, rpi_pkg::ST_MATCHED}},
    '{ROW_PIXEL, 9'd0,   24'h800000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_SIZE,  9'd3,   24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h123456, 1'b1, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h800000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    // size zero: nothing can be added
    '{ROW_SIZE,  9'd0,   24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h00FF00, 1'b1, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'hFFFFFF, 1'b1, '{8'd1, rpi_pkg::ST_MATCHED}},
    '{ROW_SIZE,  9'd1,   24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h0000FF, 1'b1, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_SIZE,  9'd5,   24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h0000FF, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h00FF00, 1'b1, '{8'd0, rpi_pkg::ST_FULL}},
    // size lowered below the count, stored colors still found
    '{ROW_SIZE,  9'd2,   24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h0000FF, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h7F7F7F, 1'b1, '{8'd0, rpi_pkg::ST_FULL}},
    // sizes above the table depth act as the depth
    '{ROW_SIZE,  9'd511, 24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h00FF00, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h010203, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_SIZE,  9'd257, 24'h000000, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'hA5A55A, 1'b0, '{8'd0, rpi_pkg::ST_FULL}},
    '{ROW_PIXEL, 9'd0,   24'h0000FF, 1'b0, '{8'd0, rpi_pkg::ST_FULL}}
  };

  rpi_pkg::cfg_t phase_sizes [N_PHASES] = '{
    9'd16, 9'd64, 9'd0, 9'd140, 9'd3, 9'd511, 9'd200, 9'd256, 9'd1, 9'd257
  };

  rgb_palette_indexer #(
    .MAX_COLORS(MAX_COLORS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_palette_index  (out_palette_index),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_palette_entries(cfg_palette_entries)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // first-fit lookup, stores the color when there is room
  function automatic result_t assign_palette_slot(rpi_pkg::color_t c);
    result_t     r;
    int unsigned eff;
    bit          hit;
    r.idx = '0;
    r.status = rpi_pkg::ST_FULL;
    hit = 1'b0;
    eff = (size_reg > MAX_COLORS) ? MAX_COLORS : size_reg;
    for (int i = 0; i < stored_count && !hit; i++) begin
      if (stored_colors[i] == c) begin
        hit = 1'b1;
        r.idx = rpi_pkg::idx_t'(i);
        r.status = rpi_pkg::ST_MATCHED;
      end
    end
    if (!hit && stored_count + 1 < eff && stored_count < MAX_COLORS) begin
      stored_colors[stored_count] = c;
      r.idx = rpi_pkg::idx_t'(stored_count);
      r.status = rpi_pkg::ST_ADDED;
      stored_count++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic offer_pixel(rpi_pkg::color_t c, bit typed, result_t expected);
    result_t pred;
    @(negedge clk);
    in_valid <= 1'b1;
    in_red   <= c[23:16];
    in_green <= c[15:8];
    in_blue  <= c[7:0];
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pred = assign_palette_slot(c);
    pending_results.push_back(typed ? expected : pred);
  endtask

  task automatic sender_gap();
    int unsigned k;
    int unsigned len;
    k = $urandom_range(0, 99);
    if (k < 60) len = 0;
    else if (k < 90) len = $urandom_range(1, 4);
    else if (k < 98) len = $urandom_range(5, 40);
    else len = $urandom_range(100, 400);
    repeat (len) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_red   <= 8'($urandom);
      in_green <= 8'($urandom);
      in_blue  <= 8'($urandom);
    end
  endtask

  // size is only changed with nothing in flight
  task automatic set_palette_size(rpi_pkg::cfg_t v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_palette_entries <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_palette_entries <= rpi_pkg::cfg_t'($urandom);
    size_reg = v;
  endtask

  // long receiver hold-off so the row freezes and the input stalls
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    int unsigned k;
    int unsigned run;
    bit          stall_now;
    forever begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        stall_now = 1'b0;
        run = $urandom_range(1, 30);
      end else if (k < 85) begin
        stall_now = 1'b1;
        run = $urandom_range(1, 5);
      end else if (k < 95) begin
        stall_now = 1'b1;
        run = $urandom_range(6, 40);
      end else if (k < 98) begin
        stall_now = 1'b1;
        run = $urandom_range(100, 600);
      end else begin
        stall_now = 1'b0;
        run = $urandom_range(1000, 3000);
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= stall_now | hold_active;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        exp = pending_results.pop_front();
        if (out_palette_index != exp.idx)
          report_mismatch($sformatf("palette_index %0d, expected %0d",
                                    out_palette_index, exp.idx));
        if (out_status != exp.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, exp.status));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned     k;
    rpi_pkg::color_t c;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SIZE) begin
        set_palette_size(directed_rows[i].size);
      end else begin
        offer_pixel(directed_rows[i].color, directed_rows[i].typed,
                    directed_rows[i].expected);
        sender_gap();
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_palette_size(phase_sizes[p]);
      if (p == 0) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        k = $urandom_range(0, 99);
        if (k < 50 && stored_count > 0) begin
          c = stored_colors[$urandom_range(0, stored_count - 1)];
        end else if (k < 65 && stored_count > 0) begin
          // one bit away from a stored color
          c = stored_colors[$urandom_range(0, stored_count - 1)]
              ^ (24'h1 << $urandom_range(0, 23));
        end else begin
          c = rpi_pkg::color_t'($urandom);
        end
        offer_pixel(c, 1'b0, '0);
        sender_gap();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
